FILE: src/cbve_pkg.sv
package cbve_pkg;

  // Field widths of the input and result words.
  localparam int IdxW    = 10;
  localparam int CountW  = 11;
  localparam int CoordW  = 16;
  localparam int EdgeW   = 16;
  localparam int SizeW   = 16;
  localparam int OutW    = 24;
  localparam int OutFracW = 4;

  // Curve parameter t is unsigned Q1.16, so t = 1.0 is exact.
  localparam int FracW = 16;
  localparam int TW    = FracW + 1;
  // Weight operands u, 3t, 3u and t share one width.
  localparam int WW    = TW + 2;
  // Weight times control point, signed.
  localparam int ProdW = WW + 1 + CoordW;
  // Half sums u*a + 3t*b and 3u*c + t*d, signed.
  localparam int HalfW = 35;
  // The half sums are split at this bit before the wide multiply.
  localparam int LoW   = 18;
  // u^2 and t^2, unsigned, at most 2^32.
  localparam int SqW   = 2 * FracW + 1;
  // The full Bernstein sum is exact in 64 bits.
  localparam int SumW  = 64;
  // Position in Q.18 after the floor shift of 44 bits.
  localparam int PosW  = CoordW + OutFracW;

  // Placement into the box: position times size, rounded to Q.4.
  localparam int PlaceW     = PosW + SizeW + 1;
  localparam int PlaceShift = 14;
  localparam int ShW        = PlaceW - PlaceShift;
  localparam logic signed [PlaceW-1:0] RoundHalf = PlaceW'(1 << (PlaceShift - 1));

  localparam int NumAxes  = 2;
  localparam int NumTerms = 4;
  localparam int AxisX    = 0;
  localparam int AxisY    = 1;
  localparam int BernLat  = 6;

  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_P1_X,
    REG_P1_Y,
    REG_P2_X,
    REG_P2_Y,
    REG_P3_X,
    REG_P3_Y,
    REG_P4_X,
    REG_P4_Y
  } reg_idx_t;

  localparam logic [CoordW-1:0] CfgReset [NumRegs] = '{
    16'h0000, 16'h0000, 16'h4000, 16'h0000,
    16'h0000, 16'h4000, 16'h4000, 16'h4000
  };

  typedef struct packed {
    logic [IdxW-1:0]          vertex_index;
    logic [CountW-1:0]        segment_count;
    logic signed [EdgeW-1:0]  box_left;
    logic signed [EdgeW-1:0]  box_top;
    logic [SizeW-1:0]         box_width;
    logic [SizeW-1:0]         box_height;
  } in_t;

  typedef struct packed {
    logic signed [OutW-1:0] vertex_x;
    logic signed [OutW-1:0] vertex_y;
  } out_t;

  typedef struct packed {
    logic signed [EdgeW-1:0] left;
    logic signed [EdgeW-1:0] top;
    logic [SizeW-1:0]        width;
    logic [SizeW-1:0]        height;
  } box_t;

  // Control points indexed by axis, then by point.
  typedef logic [NumAxes-1:0][NumTerms-1:0][CoordW-1:0] ctrl_pts_t;

  // Curve position per axis, signed Q.18.
  typedef logic [NumAxes-1:0][PosW-1:0] pos_pair_t;

endpackage

FILE: src/cubic_bezier_vertex_eval.sv
// Pipeline: 1 input stage, 17 divider stages, 6 polynomial stages and 3 placement stages;
// done is registered in the last placement stage, alongside the result.
// Throughput: one word per clock, every clock; the pipeline never holds an input off,
// so busy stays low, and the receiver takes each result in its single done cycle.
// Reset (rst, synchronous, active high) empties the pipeline and restores the
// control points to their reset values; words in flight are dropped.
module cubic_bezier_vertex_eval #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  cbve_pkg::in_t                    item,
  output logic                             done,
  output cbve_pkg::out_t                   result,
  input  logic                             cfg_we,
  input  logic [cbve_pkg::RegIdxW-1:0]     cfg_index,
  input  logic [cbve_pkg::CoordW-1:0]      cfg_data
);

  localparam int CountW   = cbve_pkg::CountW;
  localparam int IdxW     = cbve_pkg::IdxW;
  localparam int NA       = cbve_pkg::NumAxes;
  localparam int EdgeW    = cbve_pkg::EdgeW;
  localparam int SizeW    = cbve_pkg::SizeW;
  localparam int OutW     = cbve_pkg::OutW;
  localparam int OutFracW = cbve_pkg::OutFracW;
  localparam int PlaceW   = cbve_pkg::PlaceW;
  localparam int ShW      = cbve_pkg::ShW;
  localparam int CountMax = (1 << CountW) - 1;
  // A count above the limit is saturated; a limit beyond the field never bites.
  localparam logic [CountW-1:0] CountClip =
    (MAX_SEGMENTS > CountMax) ? CountW'(CountMax) : CountW'(MAX_SEGMENTS);
  localparam int Latency = 1 + cbve_pkg::TW + cbve_pkg::BernLat + 3;

  // The pipeline advances every clock and nothing downstream can stall it.
  assign busy = 1'b0;

  // Control point registers, one per index, x and y interleaved per point.
  logic [cbve_pkg::CoordW-1:0] cfg_reg [cbve_pkg::NumRegs];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbve_pkg::NumRegs; i++) begin
        cfg_reg[i] <= cbve_pkg::CfgReset[i];
      end
    end else if (cfg_we) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  cbve_pkg::ctrl_pts_t ctrl;

  always_comb begin
    ctrl[cbve_pkg::AxisX][0] = cfg_reg[cbve_pkg::REG_P1_X];
    ctrl[cbve_pkg::AxisY][0] = cfg_reg[cbve_pkg::REG_P1_Y];
    ctrl[cbve_pkg::AxisX][1] = cfg_reg[cbve_pkg::REG_P2_X];
    ctrl[cbve_pkg::AxisY][1] = cfg_reg[cbve_pkg::REG_P2_Y];
    ctrl[cbve_pkg::AxisX][2] = cfg_reg[cbve_pkg::REG_P3_X];
    ctrl[cbve_pkg::AxisY][2] = cfg_reg[cbve_pkg::REG_P3_Y];
    ctrl[cbve_pkg::AxisX][3] = cfg_reg[cbve_pkg::REG_P4_X];
    ctrl[cbve_pkg::AxisY][3] = cfg_reg[cbve_pkg::REG_P4_Y];
  end

  // Input stage: every accepted word is registered as it arrives.
  logic          in_v;
  cbve_pkg::in_t in_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    in_item <= item;
  end

  // Clamp the index to the last sample. A count of zero or one is turned into
  // index 0 over divisor 1, so the divider yields t = 0 with no special path.
  logic [CountW-1:0] cnt_sat;
  logic [CountW-1:0] last;
  logic [IdxW-1:0]   idx_c;
  cbve_pkg::box_t    in_box;

  always_comb begin
    cnt_sat = (in_item.segment_count > CountClip) ? CountClip : in_item.segment_count;
    if (cnt_sat > CountW'(1)) begin
      last  = cnt_sat - CountW'(1);
      idx_c = (CountW'(in_item.vertex_index) > last) ? last[IdxW-1:0]
                                                     : in_item.vertex_index;
    end else begin
      last  = CountW'(1);
      idx_c = '0;
    end
    in_box.left   = in_item.box_left;
    in_box.top    = in_item.box_top;
    in_box.width  = in_item.box_width;
    in_box.height = in_item.box_height;
  end

  // t = floor(index * 2^16 / last), one quotient bit per stage.
  logic                         div_v;
  logic [cbve_pkg::TW-1:0]      div_t;
  cbve_pkg::box_t               div_box;

  cbve_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_v),
    .in_rem    (CountW'(idx_c)),
    .in_div    (last),
    .in_box    (in_box),
    .out_valid (div_v),
    .out_t     (div_t),
    .out_box   (div_box)
  );

  // Cubic Bernstein sum for both axes, floored to Q.18.
  logic                 bern_v;
  cbve_pkg::pos_pair_t  bern_pos;
  cbve_pkg::box_t       bern_box;

  cbve_bern u_bern (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_v),
    .in_t      (div_t),
    .cp        (ctrl),
    .in_box    (div_box),
    .out_valid (bern_v),
    .out_pos   (bern_pos),
    .out_box   (bern_box)
  );

  // Placement: scale by the box size, round half up to Q.4, add the box edge.
  logic [SizeW-1:0]        b_size [NA];
  logic signed [EdgeW-1:0] b_edge [NA];

  always_comb begin
    b_size[cbve_pkg::AxisX] = bern_box.width;
    b_size[cbve_pkg::AxisY] = bern_box.height;
    b_edge[cbve_pkg::AxisX] = bern_box.left;
    b_edge[cbve_pkg::AxisY] = bern_box.top;
  end

  logic                     p1_v;
  logic signed [PlaceW-1:0] prod    [NA];
  logic signed [EdgeW-1:0]  p1_edge [NA];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else begin
      p1_v <= bern_v;
    end
    for (int a = 0; a < NA; a++) begin
      prod[a]    <= $signed(bern_pos[a]) * $signed({1'b0, b_size[a]});
      p1_edge[a] <= b_edge[a];
    end
  end

  logic                     p2_v;
  logic signed [PlaceW-1:0] rnd     [NA];
  logic signed [ShW-1:0]    sh      [NA];
  logic signed [EdgeW-1:0]  p2_edge [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      rnd[a] = prod[a] + cbve_pkg::RoundHalf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
    for (int a = 0; a < NA; a++) begin
      sh[a]      <= rnd[a][PlaceW-1:cbve_pkg::PlaceShift];
      p2_edge[a] <= p1_edge[a];
    end
  end

  // The final sum wraps to 24 bits; in range it never actually overflows.
  logic [OutW-1:0] xy [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      xy[a] = {{(OutW - EdgeW - OutFracW){p2_edge[a][EdgeW-1]}}, p2_edge[a],
               {OutFracW{1'b0}}}
            + {{(OutW - ShW){sh[a][ShW-1]}}, sh[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_v;
    end
    result.vertex_x <= xy[cbve_pkg::AxisX];
    result.vertex_y <= xy[cbve_pkg::AxisY];
  end

  // Every accepted word comes out exactly once.
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(Latency) done)
    else $error("accepted word produced no result");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without an accepted word");

endmodule

FILE: src/cbve_div.sv
module cbve_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [cbve_pkg::CountW-1:0]    in_rem,
  input  logic [cbve_pkg::CountW-1:0]    in_div,
  input  cbve_pkg::box_t                 in_box,
  output logic                           out_valid,
  output logic [cbve_pkg::TW-1:0]        out_t,
  output cbve_pkg::box_t                 out_box
);

  localparam int TW   = cbve_pkg::TW;
  localparam int RemW = cbve_pkg::CountW;
  localparam logic [TW-1:0] TOne = {1'b1, {cbve_pkg::FracW{1'b0}}};

  // Index 0 is the incoming word; stage k settles quotient bit TW-k.
  logic                 st_v   [TW+1];
  logic [RemW-1:0]      st_r   [TW+1];
  logic [RemW-1:0]      st_d   [TW+1];
  logic [TW-1:0]        st_q   [TW+1];
  cbve_pkg::box_t       st_box [TW+1];
  logic [RemW:0]        trial  [TW+1];
  logic [RemW:0]        diff   [TW+1];
  logic                 ge     [TW+1];

  assign st_v[0]   = in_valid;
  assign st_r[0]   = in_rem;
  assign st_d[0]   = in_div;
  assign st_q[0]   = '0;
  assign st_box[0] = in_box;

  // The first step compares the index itself (it may equal the divisor);
  // every later step doubles a remainder that is below the divisor.
  always_comb begin
    trial[0] = '0;
    diff[0]  = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k <= TW; k++) begin
      if (k == 1) begin
        trial[k] = {1'b0, st_r[k-1]};
      end else begin
        trial[k] = {st_r[k-1], 1'b0};
      end
      diff[k] = trial[k] - {1'b0, st_d[k-1]};
      ge[k]   = trial[k] >= {1'b0, st_d[k-1]};
    end
  end

  for (genvar k = 1; k <= TW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k] <= 1'b0;
      end else begin
        st_v[k] <= st_v[k-1];
      end
      st_r[k]   <= ge[k] ? diff[k][RemW-1:0] : trial[k][RemW-1:0];
      st_d[k]   <= st_d[k-1];
      st_q[k]   <= {st_q[k-1][TW-2:0], ge[k]};
      st_box[k] <= st_box[k-1];
    end
  end

  assign out_valid = st_v[TW];
  assign out_t     = st_q[TW];
  assign out_box   = st_box[TW];

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_t <= TOne)
    else $error("curve parameter above one");

endmodule

FILE: src/cbve_bern.sv
module cbve_bern (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [cbve_pkg::TW-1:0]     in_t,
  input  cbve_pkg::ctrl_pts_t         cp,
  input  cbve_pkg::box_t              in_box,
  output logic                        out_valid,
  output cbve_pkg::pos_pair_t         out_pos,
  output cbve_pkg::box_t              out_box
);

  localparam int TW    = cbve_pkg::TW;
  localparam int WW    = cbve_pkg::WW;
  localparam int NA    = cbve_pkg::NumAxes;
  localparam int NT    = cbve_pkg::NumTerms;
  localparam int ProdW = cbve_pkg::ProdW;
  localparam int HalfW = cbve_pkg::HalfW;
  localparam int LoW   = cbve_pkg::LoW;
  localparam int SqW   = cbve_pkg::SqW;
  localparam int SumW  = cbve_pkg::SumW;
  localparam int PosW  = cbve_pkg::PosW;
  localparam int Lat   = cbve_pkg::BernLat;
  localparam int HiPW  = (HalfW - LoW) + SqW + 1;
  localparam int LoPW  = LoW + 1 + SqW + 1;
  localparam logic [TW-1:0] TOne = {1'b1, {cbve_pkg::FracW{1'b0}}};

  logic           v  [Lat];
  cbve_pkg::box_t bx [Lat];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Lat; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      v[0] <= in_valid;
      for (int k = 1; k < Lat; k++) begin
        v[k] <= v[k-1];
      end
    end
    bx[0] <= in_box;
    for (int k = 1; k < Lat; k++) begin
      bx[k] <= bx[k-1];
    end
  end

  // Weights: the sum is u^2 (u a + 3t b) + t^2 (3u c + t d).
  logic [TW-1:0] u_in;
  logic [WW-1:0] w [NT];

  assign u_in = TOne - in_t;

  always_ff @(posedge clk) begin
    w[0] <= WW'(u_in);
    w[1] <= WW'({in_t, 1'b0}) + WW'(in_t);
    w[2] <= WW'({u_in, 1'b0}) + WW'(u_in);
    w[3] <= WW'(in_t);
  end

  logic [2*TW-1:0]          uu_full;
  logic [2*TW-1:0]          tt_full;
  logic signed [ProdW-1:0]  pr  [NA][NT];
  logic [SqW-1:0]           sq2 [2];

  assign uu_full = w[0][TW-1:0] * w[0][TW-1:0];
  assign tt_full = w[3][TW-1:0] * w[3][TW-1:0];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      for (int j = 0; j < NT; j++) begin
        pr[a][j] <= $signed({1'b0, w[j]}) * $signed(cp[a][j]);
      end
    end
    sq2[0] <= uu_full[SqW-1:0];
    sq2[1] <= tt_full[SqW-1:0];
  end

  logic signed [HalfW-1:0] h   [NA][2];
  logic [SqW-1:0]          sq3 [2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      h[a][0] <= pr[a][0][HalfW-1:0] + pr[a][1][HalfW-1:0];
      h[a][1] <= pr[a][2][HalfW-1:0] + pr[a][3][HalfW-1:0];
    end
    sq3 <= sq2;
  end

  // Each half sum times its square, as a high and a low partial product.
  logic signed [HiPW-1:0] ph [NA][2];
  logic signed [LoPW-1:0] pl [NA][2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      for (int k = 0; k < 2; k++) begin
        ph[a][k] <= $signed(h[a][k][HalfW-1:LoW]) * $signed({1'b0, sq3[k]});
        pl[a][k] <= $signed({1'b0, h[a][k][LoW-1:0]}) * $signed({1'b0, sq3[k]});
      end
    end
  end

  // Sums wrap modulo 2^64; the true total always fits.
  logic [SumW-1:0] q [NA][2];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      for (int k = 0; k < 2; k++) begin
        q[a][k] <= {ph[a][k][SumW-LoW-1:0], {LoW{1'b0}}} + SumW'(pl[a][k]);
      end
    end
  end

  logic [SumW-1:0]     s [NA];
  cbve_pkg::pos_pair_t pos6;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      s[a] = q[a][0] + q[a][1];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      pos6[a] <= s[a][SumW-1:SumW-PosW];
    end
  end

  assign out_valid = v[Lat-1];
  assign out_pos   = pos6;
  assign out_box   = bx[Lat-1];

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, Lat))
    else $error("position valid without a matching input");

  a_first_point: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_t == '0 |-> ##(Lat)
      (out_pos[0] == {$past(cp[0][0], Lat - 1), {(PosW - cbve_pkg::CoordW){1'b0}}}) &&
      (out_pos[1] == {$past(cp[1][0], Lat - 1), {(PosW - cbve_pkg::CoordW){1'b0}}}))
    else $error("curve start differs from first control point");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The block must clamp counts above this value, so the instance uses it explicitly.
  localparam int MaxSegments = 1024;
  // Cycles with no accepted word and no result before the run is declared hung.
  localparam int StallLimit  = 5000;
  // Margin after the last expected result.
  localparam int DrainCycles = 40;
  localparam int RandPerPhase = 175;
  localparam int NumPhases    = 6;
  localparam int MaxReports   = 10;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  cbve_pkg::in_t  item;
  logic done;
  cbve_pkg::out_t result;
  logic cfg_we;
  logic [cbve_pkg::RegIdxW-1:0] cfg_index;
  logic [cbve_pkg::CoordW-1:0]  cfg_data;

  cubic_bezier_vertex_eval #(
    .MAX_SEGMENTS(MaxSegments)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be driven, and the vertices the block owes us, oldest first.
  cbve_pkg::in_t  pending_requests[$];
  cbve_pkg::out_t expected_vertices[$];

  // Our own copy of the control points, sign extended, indexed by register.
  longint ctrl_pt [cbve_pkg::NumRegs];
  // Values that the next configuration pass loads into the block.
  logic [cbve_pkg::CoordW-1:0] next_ctrl [cbve_pkg::NumRegs];

  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned vertices_checked = 0;
  int unsigned fail_count = 0;
  int unsigned idle_pct = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  bit word_taken = 1'b0;
  bit drv_send;
  cbve_pkg::out_t want;

  // Bernstein sum of one axis. The weights sum to 2^48 and every partial sum
  // stays inside 64 bits, so plain signed arithmetic is exact here. The arithmetic
  // shift by 44 is the floor that leaves a Q.18 position.
  function automatic longint curve_axis(input longint w0, input longint w1,
                                        input longint w2, input longint w3,
                                        input longint a, input longint b,
                                        input longint c, input longint d);
    longint s;
    s = w0 * a + w1 * b + w2 * c + w3 * d;
    return s >>> 44;
  endfunction

  // Scale a Q.18 position by the box size, round half up to Q.4, add the edge.
  function automatic longint place_axis(input longint pos, input longint size,
                                        input longint edge_px);
    longint prod;
    prod = pos * size;
    return edge_px * 16 + ((prod + 64'sd8192) >>> 14);
  endfunction

  // Expected vertex for one request word under the current control points.
  function automatic cbve_pkg::out_t predict_vertex(input cbve_pkg::in_t w);
    longint unsigned idx, cnt, last, t, u;
    longint w0, w1, w2, w3, pos_x, pos_y, px, py;
    cbve_pkg::out_t r;
    idx = w.vertex_index;
    cnt = w.segment_count;
    // Counts past the maximum saturate; a count of zero or one pins t at zero.
    if (cnt > MaxSegments) cnt = MaxSegments;
    t = 0;
    if (cnt > 1) begin
      last = cnt - 1;
      // An index past the last sample is clamped onto it.
      if (idx > last) idx = last;
      t = (idx << 16) / last;
    end
    u = 64'd65536 - t;
    w0 = longint'(u * u * u);
    w1 = longint'(3 * u * u * t);
    w2 = longint'(3 * u * t * t);
    w3 = longint'(t * t * t);
    pos_x = curve_axis(w0, w1, w2, w3,
                       ctrl_pt[cbve_pkg::REG_P1_X], ctrl_pt[cbve_pkg::REG_P2_X],
                       ctrl_pt[cbve_pkg::REG_P3_X], ctrl_pt[cbve_pkg::REG_P4_X]);
    pos_y = curve_axis(w0, w1, w2, w3,
                       ctrl_pt[cbve_pkg::REG_P1_Y], ctrl_pt[cbve_pkg::REG_P2_Y],
                       ctrl_pt[cbve_pkg::REG_P3_Y], ctrl_pt[cbve_pkg::REG_P4_Y]);
    px = place_axis(pos_x, longint'(w.box_width), longint'($signed(w.box_left)));
    py = place_axis(pos_y, longint'(w.box_height), longint'($signed(w.box_top)));
    r.vertex_x = px[cbve_pkg::OutW-1:0];
    r.vertex_y = py[cbve_pkg::OutW-1:0];
    return r;
  endfunction

  // Box fields lean on their extremes so that corner cases come up often.
  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cbve_pkg::in_t random_request();
    cbve_pkg::in_t w;
    int unsigned cnt, lim;
    // Mostly legal counts, with zero, one, the maximum and oversized counts mixed in.
    case ($urandom_range(15))
      0: cnt = 0;
      1: cnt = 1;
      2: cnt = $urandom_range(2047, 1025);
      3: cnt = MaxSegments;
      4: cnt = 2;
      default: cnt = $urandom_range(MaxSegments, 1);
    endcase
    if (cnt > MaxSegments) lim = MaxSegments - 1;
    else if (cnt == 0) lim = 0;
    else lim = cnt - 1;
    w.segment_count = cbve_pkg::CountW'(cnt);
    case ($urandom_range(15))
      0, 1: w.vertex_index = cbve_pkg::IdxW'($urandom);   // may land past the end
      2: w.vertex_index = cbve_pkg::IdxW'(lim);           // last sample, t of one unless the count is below two
      3: w.vertex_index = '0;
      default: w.vertex_index = cbve_pkg::IdxW'($urandom_range(lim, 0));
    endcase
    w.box_left   = pick16();
    w.box_top    = pick16();
    w.box_width  = pick16();
    w.box_height = pick16();
    return w;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("mismatch: %s", msg);
  endfunction

  task automatic push_request(input int idx, input int cnt, input int left,
                              input int top, input int wid, input int hgt);
    cbve_pkg::in_t w;
    w.vertex_index  = cbve_pkg::IdxW'(idx);
    w.segment_count = cbve_pkg::CountW'(cnt);
    w.box_left      = cbve_pkg::EdgeW'(left);
    w.box_top       = cbve_pkg::EdgeW'(top);
    w.box_width     = cbve_pkg::SizeW'(wid);
    w.box_height    = cbve_pkg::SizeW'(hgt);
    pending_requests.push_back(w);
    words_queued++;
  endtask

  // Loads next_ctrl into the block one register per cycle. It is only called
  // while nothing is in flight, so updating our copy right away is safe.
  task automatic load_ctrl_points();
    for (int r = 0; r < cbve_pkg::NumRegs; r++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= cbve_pkg::RegIdxW'(r);
      cfg_data  <= next_ctrl[r];
      ctrl_pt[r] = longint'($signed(next_ctrl[r]));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued word has been taken and every vertex has come back,
  // then lets the pipeline settle. The watchdog bounds the wait.
  task automatic wait_drained();
    do @(negedge clk);
    while (!(words_taken == words_queued && expected_vertices.size() == 0));
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Driver. Inputs move on the falling edge only. A word stays on the port until
  // the rising edge takes it; only then is the next one chosen, so start is
  // assigned once per falling edge and never dropped between back-to-back words.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      drv_send = 1'b0;
      if (pending_requests.size() != 0) begin
        if (burst_left != 0) begin
          // A stretch with no idling even in the sparse phases.
          drv_send = 1'b1;
          burst_left--;
        end else if (idle_pct != 0 && $urandom_range(63) == 0) begin
          burst_left = $urandom_range(60, 20);
        end else begin
          drv_send = ($urandom_range(99) >= idle_pct);
        end
      end
      if (drv_send) item <= pending_requests.pop_front();
      start <= drv_send;
    end
  end

  // Monitor. Sampling on the rising edge sees the values that edge acts on.
  // A word is taken when start is high and busy low; its vertex is predicted at
  // that moment, since the control points cannot change while words are in flight.
  // A result lives for exactly one done cycle and is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    word_taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_vertices.size() == 0) begin
          note_failure($sformatf("vertex with nothing expected: x=%0d y=%0d",
                                 result.vertex_x, result.vertex_y));
        end else begin
          want = expected_vertices.pop_front();
          if (result.vertex_x !== want.vertex_x || result.vertex_y !== want.vertex_y)
            note_failure($sformatf("vertex %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                   vertices_checked, want.vertex_x, want.vertex_y,
                                   result.vertex_x, result.vertex_y));
          vertices_checked++;
        end
      end
      if (start && !busy) begin
        word_taken = 1'b1;
        expected_vertices.push_back(predict_vertex(item));
        words_taken++;
      end
    end
  end

  // Watchdog: ends the run if nothing moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int r = 0; r < cbve_pkg::NumRegs; r++)
      ctrl_pt[r] = longint'($signed(cbve_pkg::CfgReset[r]));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Control-point setting and sender pacing for this phase. The first phase
      // runs on the reset values; every later one rewrites all registers.
      case (ph)
        1: for (int r = 0; r < cbve_pkg::NumRegs; r++) next_ctrl[r] = 16'h7fff;
        2: for (int r = 0; r < cbve_pkg::NumRegs; r++) next_ctrl[r] = 16'h8000;
        3: for (int r = 0; r < cbve_pkg::NumRegs; r++)
             next_ctrl[r] = r[0] ? 16'h7fff : 16'h8000;
        default: for (int r = 0; r < cbve_pkg::NumRegs; r++) next_ctrl[r] = 16'($urandom);
      endcase
      case (ph)
        1, 4: idle_pct = 84;
        3, 5: idle_pct = 23;
        default: idle_pct = 0;
      endcase
      burst_left = 0;
      if (ph != 0) load_ctrl_points();

      if (ph == 0) begin
        // Single sample and zero count both sit on the first control point.
        push_request(0, 1, 0, 0, 100, 100);
        push_request(0, 0, 0, 0, 100, 100);
        push_request(5, 0, 10, 20, 100, 100);
        push_request(1023, 1, 0, 0, 100, 100);
        // First, middle and last sample of the largest legal count.
        push_request(0, 1024, 0, 0, 640, 480);
        push_request(512, 1024, 0, 0, 640, 480);
        push_request(1023, 1024, 0, 0, 640, 480);
        // Oversized counts saturate to the maximum.
        push_request(1023, 2047, 0, 0, 640, 480);
        push_request(700, 1500, 0, 0, 640, 480);
        push_request(1023, 1025, 0, 0, 640, 480);
        // Two, three and five samples and a count of 1023; an index past the end is clamped.
        push_request(1, 2, 0, 0, 300, 200);
        push_request(0, 2, 0, 0, 300, 200);
        push_request(9, 5, 0, 0, 300, 200);
        push_request(1, 3, 0, 0, 300, 200);
        push_request(1022, 1023, 0, 0, 300, 200);
        // Box corners.
        push_request(0, 1, -32768, -32768, 0, 0);
        push_request(1023, 1024, 32767, 32767, 65535, 65535);
        push_request(512, 1024, -32768, 32767, 65535, 0);
        push_request(511, 1024, 32767, -32768, 0, 65535);
        push_request(333, 1000, -1, -1, 65535, 65535);
        push_request(1023, 2047, -32768, -32768, 65535, 65535);
        push_request(3, 7, 1234, -4321, 640, 480);
      end
      for (int n = 0; n < RandPerPhase; n++) begin
        pending_requests.push_back(random_request());
        words_queued++;
      end
      wait_drained();
    end

    if (expected_vertices.size() != 0)
      note_failure($sformatf("%0d expected vertices never arrived",
                             expected_vertices.size()));
    $display("Checked %0d vertices from %0d request words over %0d control-point settings.",
             vertices_checked, words_taken, NumPhases);
    $display("Pacing ranged from back-to-back to mostly idle; zero, single and oversized counts included.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
